FILE: src/rsc_pkg.sv
// shared types, constants and lookup tables for the remote setpoint controller
// no dependencies

package rsc_pkg;

	localparam int QDEPTH_DEF = 2;

	localparam int SENSE_W = 16;
	localparam int BATT_W  = 13;
	localparam int CMD_W   = 8;
	localparam int LVL_W   = 8;

	localparam int DIV_DW = 24;
	localparam int DIV_VW = BATT_W;
	localparam int DIV_CW = $clog2(DIV_DW);

	localparam logic [0:0] REG_SENSE  = 1'b0;
	localparam logic [0:0] REG_LOWBAT = 1'b1;

	localparam logic [SENSE_W-1:0] SENSE_RST  = 16'd1000;
	localparam logic [BATT_W-1:0]  LOWBAT_RST = 13'd2500;

	localparam logic [CMD_W-1:0] CMD_UP    = 8'hA0;
	localparam logic [CMD_W-1:0] CMD_DOWN  = 8'hB0;
	localparam logic [CMD_W-1:0] CMD_RIGHT = 8'h50;
	localparam logic [CMD_W-1:0] CMD_LEFT  = 8'h10;
	localparam logic [CMD_W-1:0] CMD_FRST  = 8'h88;
	localparam logic [CMD_W-1:0] CMD_CRST  = 8'h48;

	localparam logic [3:0] CUR_MAX  = 4'd10;
	localparam logic [3:0] CUR_RST  = 4'd5;
	localparam logic [2:0] FREQ_MAX = 3'd5;
	localparam logic [2:0] FREQ_RST = 3'd3;

	localparam logic [LVL_W-1:0] PERIOD_RST = 8'd86;
	localparam logic [LVL_W-1:0] LVL_MAX    = 8'd255;
	localparam logic [8:0]       MV_ROUND   = 9'd500;

	// x/1000 as (x*ceil(2^34/1000)) >> 34, exact for every 24-bit x
	localparam int               RECIP_W  = 25;
	localparam logic [RECIP_W-1:0] MV_RECIP = 25'd17179870;
	localparam int               MV_SHIFT = 34;
	localparam int               DROP_W   = 15;

	typedef enum logic [1:0] {
		MODE_RUN,
		MODE_CUR,
		MODE_FREQ,
		MODE_LOW
	} mode_t;

	typedef enum logic [2:0] {
		IND_NONE,
		IND_INC,
		IND_DEC,
		IND_LIMIT,
		IND_FREQ,
		IND_CUR,
		IND_RESET
	} ind_t;

	typedef enum logic [2:0] {
		OP_BATT,
		OP_UP,
		OP_DOWN,
		OP_RIGHT,
		OP_LEFT,
		OP_FRST,
		OP_CRST,
		OP_NONE
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_RECIP,
		ST_SUB,
		ST_START,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		op_t               op;
		logic [BATT_W-1:0] batt;
	} item_t;

	typedef struct packed {
		logic              start;
		logic [DIV_DW-1:0] dividend;
		logic [DIV_VW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_DW-1:0] quotient;
	} div_rsp_t;

	// packed so that dac_level sits in the lowest bits
	typedef struct packed {
		logic             battery_low;
		logic             save_request;
		ind_t             indication;
		mode_t            menu_mode;
		logic             steady_output;
		logic [LVL_W-1:0] timer_period;
		logic [LVL_W-1:0] dac_level;
	} res_t;

	// current in uA per step
	function automatic logic [7:0] cur_ua(input logic [3:0] step);
		logic [7:0] ua;
		case (step)
			4'd0:    ua = 8'd0;
			4'd1:    ua = 8'd30;
			4'd2:    ua = 8'd50;
			4'd3:    ua = 8'd70;
			4'd4:    ua = 8'd90;
			4'd5:    ua = 8'd110;
			4'd6:    ua = 8'd130;
			4'd7:    ua = 8'd160;
			4'd8:    ua = 8'd190;
			4'd9:    ua = 8'd220;
			default: ua = 8'd250;
		endcase
		return ua;
	endfunction

	// timer period per frequency step, 1e6/(96*f) clamped to 68..255
	function automatic logic [7:0] freq_period(input logic [2:0] step);
		logic [7:0] p;
		case (step)
			3'd0:    p = 8'd255;
			3'd1:    p = 8'd208;
			3'd2:    p = 8'd104;
			3'd3:    p = 8'd86;
			3'd4:    p = 8'd80;
			default: p = 8'd74;
		endcase
		return p;
	endfunction

endpackage

FILE: src/rsc_front.sv
// input side: accepts words, decodes them into operations and queues them
// depends on rsc_pkg

module rsc_front
	import rsc_pkg::*;
#(
	parameter int DEPTH = QDEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_valid,
	output logic              s_ready,
	input  logic              s_kind,
	input  logic [BATT_W-1:0] s_batt,
	input  logic [CMD_W-1:0]  s_cmd,
	output logic              q_valid,
	output item_t             q_item,
	input  logic              q_pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	item_t          dec_item;
	logic           push;

	always_comb begin
		dec_item.batt = s_batt;
		if (!s_kind) begin
			dec_item.op = OP_BATT;
		end else begin
			unique case (s_cmd)
				CMD_UP:    dec_item.op = OP_UP;
				CMD_DOWN:  dec_item.op = OP_DOWN;
				CMD_RIGHT: dec_item.op = OP_RIGHT;
				CMD_LEFT:  dec_item.op = OP_LEFT;
				CMD_FRST:  dec_item.op = OP_FRST;
				CMD_CRST:  dec_item.op = OP_CRST;
				default:   dec_item.op = OP_NONE;
			endcase
		end
	end

	assign s_ready = (count_q != CW'(DEPTH));
	assign push    = s_valid && s_ready;
	assign q_valid = (count_q != '0);
	assign q_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= dec_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/rsc_div.sv
// restoring divider, one quotient bit per cycle, for the dac level scaling by the supply
// depends on rsc_pkg

module rsc_div
	import rsc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [DIV_DW-1:0] quo_q;
	logic [DIV_VW-1:0] rem_q;
	logic [DIV_VW-1:0] dsr_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_VW:0]   rem_sh;
	logic [DIV_VW:0]   diff;

	assign rem_sh = {rem_q, quo_q[DIV_DW-1]};
	assign diff   = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[DIV_VW]) begin
				rem_q <= diff[DIV_VW-1:0];
				quo_q <= {quo_q[DIV_DW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DIV_VW-1:0];
				quo_q <= {quo_q[DIV_DW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CW'(DIV_DW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

FILE: src/rsc_back.sv
// execution side: menu state, step indices, dac and period computation, result register
// depends on rsc_pkg; drives the rsc_div unit

module rsc_back
	import rsc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [SENSE_W-1:0] sense_ohms,
	input  logic [BATT_W-1:0]  low_mv,
	input  logic               q_valid,
	input  item_t              q_item,
	output logic               q_pop,
	output div_req_t           div_req,
	input  div_rsp_t           div_rsp,
	output logic               res_valid,
	input  logic               res_ready,
	output res_t               res
);

	state_t            state_q;
	state_t            state_nx;

	mode_t             mode_q;
	logic [3:0]        cur_q;
	logic [2:0]        freq_q;
	logic [BATT_W-1:0] batt_q;
	logic [LVL_W-1:0]  dac_q;
	logic [LVL_W-1:0]  period_q;
	logic              steady_q;
	logic              low_q;
	ind_t              ind_q;
	logic              save_q;

	logic              out_valid_q;
	res_t              out_q;

	logic [DIV_DW-1:0] prod_s1;
	logic [DROP_W-1:0] drop_s2;
	logic [DIV_DW-1:0] num_s3;

	mode_t             nx_mode;
	logic [3:0]        nx_cur;
	logic [2:0]        nx_freq;
	logic [BATT_W-1:0] nx_batt;
	logic [LVL_W-1:0]  nx_period;
	logic              nx_steady;
	logic              nx_low;
	ind_t              nx_ind;
	logic              nx_save;
	logic              need_dac;

	logic              out_free;
	logic              pop;
	logic              dac_we;
	logic [LVL_W-1:0]  dac_val;
	logic              load_prod;
	logic              load_drop;
	logic              load_num;
	logic              load_out;

	logic [DIV_DW+RECIP_W-1:0] drop_full;
	logic signed [15:0] vdac;
	logic signed [23:0] num;

	assign out_free = !out_valid_q || res_ready;

	// decode of one operation against the current state
	always_comb begin
		nx_mode   = mode_q;
		nx_cur    = cur_q;
		nx_freq   = freq_q;
		nx_batt   = batt_q;
		nx_period = period_q;
		nx_steady = steady_q;
		nx_low    = low_q;
		nx_ind    = IND_NONE;
		nx_save   = 1'b0;
		need_dac  = 1'b0;
		unique case (q_item.op) inside
			OP_BATT: begin
				nx_batt  = q_item.batt;
				nx_low   = (q_item.batt < low_mv);
				if (nx_low) begin
					nx_mode = MODE_LOW;
				end
				need_dac = 1'b1;
			end
			OP_UP, OP_DOWN: begin
				if (mode_q == MODE_CUR) begin
					if (q_item.op == OP_UP) begin
						if (cur_q >= CUR_MAX) begin
							nx_cur = CUR_MAX;
							nx_ind = IND_LIMIT;
						end else begin
							nx_cur = cur_q + 1'b1;
							nx_ind = IND_INC;
						end
					end else if (cur_q == '0) begin
						nx_ind = IND_LIMIT;
					end else begin
						nx_cur = cur_q - 1'b1;
						nx_ind = IND_DEC;
					end
					need_dac = 1'b1;
					nx_save  = 1'b1;
				end else if (mode_q == MODE_FREQ) begin
					if (q_item.op == OP_UP) begin
						if (freq_q >= FREQ_MAX) begin
							nx_freq = FREQ_MAX;
							nx_ind  = IND_LIMIT;
						end else begin
							nx_freq = freq_q + 1'b1;
							nx_ind  = IND_INC;
						end
					end else if (freq_q == '0) begin
						nx_ind = IND_LIMIT;
					end else begin
						nx_freq = freq_q - 1'b1;
						nx_ind  = IND_DEC;
					end
					nx_period = freq_period(nx_freq);
					nx_steady = (nx_freq == '0);
					nx_save   = 1'b1;
				end else begin
					nx_ind = IND_LIMIT;
				end
			end
			OP_RIGHT: begin
				nx_mode = MODE_FREQ;
				nx_ind  = IND_FREQ;
			end
			OP_LEFT: begin
				nx_mode = MODE_CUR;
				nx_ind  = IND_CUR;
			end
			OP_FRST: begin
				nx_freq   = '0;
				nx_period = freq_period(3'd0);
				nx_steady = 1'b1;
				nx_ind    = IND_RESET;
			end
			OP_CRST: begin
				nx_cur   = '0;
				nx_ind   = IND_RESET;
				need_dac = 1'b1;
			end
			default: begin
				nx_ind = IND_NONE;
			end
		endcase
	end

	// round(R*uA/1000) by reciprocal multiplication
	assign drop_full = {{RECIP_W{1'b0}}, prod_s1} * {{DIV_DW{1'b0}}, MV_RECIP};

	// vdac = vdd - round(R*uA/1000), then 256*vdac + vdd/2
	assign vdac = $signed({3'b000, batt_q}) - $signed({1'b0, drop_s2});
	assign num  = $signed({vdac, 8'h00}) + $signed({12'h000, batt_q[BATT_W-1:1]});

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid && out_free) begin
					state_nx = need_dac ? ST_MUL : ST_FIN;
				end
			end
			ST_MUL:   state_nx = (batt_q == '0) ? ST_FIN : ST_RECIP;
			ST_RECIP: state_nx = ST_SUB;
			ST_SUB:   state_nx = num[23] ? ST_FIN : ST_START;
			ST_START: state_nx = ST_DIV;
			ST_DIV: begin
				if (div_rsp.done) begin
					state_nx = ST_FIN;
				end
			end
			ST_FIN:   state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		pop              = 1'b0;
		dac_we           = 1'b0;
		dac_val          = '0;
		load_prod        = 1'b0;
		load_drop        = 1'b0;
		load_num         = 1'b0;
		load_out         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = num_s3;
		div_req.divisor  = batt_q;
		unique case (state_q)
			ST_IDLE: pop = q_valid && out_free;
			ST_MUL: begin
				load_prod = 1'b1;
				if (batt_q == '0) begin
					dac_we = 1'b1;
				end
			end
			ST_RECIP: load_drop = 1'b1;
			ST_SUB: begin
				load_num = 1'b1;
				if (num[23]) begin
					dac_we = 1'b1;
				end
			end
			ST_START: div_req.start = 1'b1;
			ST_DIV: begin
				if (div_rsp.done) begin
					dac_we  = 1'b1;
					dac_val = (|div_rsp.quotient[DIV_DW-1:LVL_W]) ? LVL_MAX
						: div_rsp.quotient[LVL_W-1:0];
				end
			end
			ST_FIN:   load_out = 1'b1;
			default:  ;
		endcase
	end

	assign q_pop = pop;

	always_ff @(posedge clk) begin
		if (load_prod) begin
			prod_s1 <= {8'h00, sense_ohms} * {16'h0000, cur_ua(cur_q)} + {15'h0000, MV_ROUND};
		end
		if (load_drop) begin
			drop_s2 <= drop_full[MV_SHIFT +: DROP_W];
		end
		if (load_num) begin
			num_s3 <= num;
		end
		if (load_out) begin
			out_q.dac_level     <= dac_q;
			out_q.timer_period  <= period_q;
			out_q.steady_output <= steady_q;
			out_q.menu_mode     <= mode_q;
			out_q.indication    <= ind_q;
			out_q.save_request  <= save_q;
			out_q.battery_low   <= low_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_RUN;
			cur_q       <= CUR_RST;
			freq_q      <= FREQ_RST;
			batt_q      <= '0;
			dac_q       <= '0;
			period_q    <= PERIOD_RST;
			steady_q    <= 1'b0;
			low_q       <= 1'b0;
			ind_q       <= IND_NONE;
			save_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (pop) begin
				mode_q   <= nx_mode;
				cur_q    <= nx_cur;
				freq_q   <= nx_freq;
				batt_q   <= nx_batt;
				period_q <= nx_period;
				steady_q <= nx_steady;
				low_q    <= nx_low;
				ind_q    <= nx_ind;
				save_q   <= nx_save;
			end
			if (dac_we) begin
				dac_q <= dac_val;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

FILE: src/remote_setpoint_controller.sv
// Remote setpoint controller. Each input word (a battery sample or a remote command byte)
// gives exactly one result word carrying the held DAC level, timer period, steady flag,
// menu mode, indication, save request and low-battery flag. Words are decoded on entry
// and queued (QUEUE_DEPTH entries), so input and output stall independently. A word that
// changes neither current nor supply goes from the queue to the result register without any
// arithmetic; a word that recomputes the DAC level (battery sample, current up/down, current
// reset) passes through a 24-step restoring divider that scales by the supply (the rounding
// to millivolts is a reciprocal multiplication). While the supply is unknown the DAC level
// is 0 and the divider is skipped. Configuration writes take effect at once.

module remote_setpoint_controller
	import rsc_pkg::*;
#(
	parameter int QUEUE_DEPTH = QDEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [23:0]        s_axis_tdata,  // battery_mv[12:0], command[20:13], zero pad
	input  logic               s_axis_tuser,  // kind
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [23:0]        m_axis_tdata,  // dac_level, timer_period, steady_output,
	                                          // menu_mode, indication, save_request,
	                                          // battery_low
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [SENSE_W-1:0] cfg_data
);

	logic [SENSE_W-1:0] sense_q;
	logic [BATT_W-1:0]  lowbat_q;
	logic               q_valid;
	item_t              q_item;
	logic               q_pop;
	div_req_t           div_req;
	div_rsp_t           div_rsp;
	res_t               res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sense_q  <= SENSE_RST;
			lowbat_q <= LOWBAT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SENSE:  sense_q  <= cfg_data;
				REG_LOWBAT: lowbat_q <= cfg_data[BATT_W-1:0];
				default:    ;
			endcase
		end
	end

	rsc_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.s_kind  (s_axis_tuser),
		.s_batt  (s_axis_tdata[12:0]),
		.s_cmd   (s_axis_tdata[20:13]),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	rsc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	rsc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.sense_ohms (sense_q),
		.low_mv     (lowbat_q),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.div_req    (div_req),
		.div_rsp    (div_rsp),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res        (res)
	);

	assign m_axis_tdata = {res.battery_low, res.save_request, res.indication, res.menu_mode,
		res.steady_output, res.timer_period, res.dac_level};

endmodule

FILE: test/remote_setpoint_controller_checker.sv
`timescale 1ns / 1ps
// checker for the remote setpoint controller: follows the words taken on both streams,
// predicts the result word of every accepted input word and compares it field by field
// depends on rsc_pkg for the command codes, register indexes, enums and result layout

module remote_setpoint_controller_checker
	import rsc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	input  logic               s_axis_tready,
	input  logic [23:0]        s_axis_tdata,  // battery_mv[12:0], command[20:13], zero pad
	input  logic               s_axis_tuser,  // kind
	input  logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	input  logic [23:0]        m_axis_tdata,  // dac_level, timer_period, steady_output,
	                                          // menu_mode, indication, save_request,
	                                          // battery_low
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [SENSE_W-1:0] cfg_data,
	output int                 mismatches,
	output int                 outstanding
);

	int microamps [0:10] = '{0, 30, 50, 70, 90, 110, 130, 160, 190, 220, 250};
	int hertz [0:5] = '{0, 50, 100, 120, 130, 140};

	logic [SENSE_W-1:0] sense_ohms;
	logic [BATT_W-1:0]  low_mv;
	mode_t              mode;
	logic [3:0]         cur_step;
	logic [2:0]         freq_step;
	logic [BATT_W-1:0]  supply_mv;
	logic [LVL_W-1:0]   dac_level;
	logic [LVL_W-1:0]   period;
	logic               steady;
	logic               low;
	res_t               pending_results [$];

	// level that drives the selected current through the sense resistor
	function automatic logic [LVL_W-1:0] level_for_current();
		longint vdd;
		longint ohms;
		longint drop;
		longint lvl;
		vdd = supply_mv;
		ohms = sense_ohms;
		if (vdd == 0)
			return '0;
		drop = (ohms * microamps[cur_step] + 500) / 1000;
		lvl = (256 * (vdd - drop) + vdd / 2) / vdd;
		if (lvl > 255)
			lvl = 255;
		if (lvl < 0)
			lvl = 0;
		return lvl[LVL_W-1:0];
	endfunction

	task automatic retime_output();
		int f;
		int p;
		f = hertz[freq_step];
		if (f == 0) begin
			period = LVL_MAX;
			steady = 1'b1;
		end else begin
			p = 1000000 / (96 * f);
			if (p > 255)
				p = 255;
			if (p < 68)
				p = 68;
			period = p[LVL_W-1:0];
			steady = 1'b0;
		end
	endtask

	task automatic apply_word(input logic kind, input logic [BATT_W-1:0] mv,
			input logic [CMD_W-1:0] cmd, output res_t r);
		ind_t ind;
		logic save;
		ind = IND_NONE;
		save = 1'b0;
		if (!kind) begin
			supply_mv = mv;
			low = (mv < low_mv);
			if (low)
				mode = MODE_LOW;
			dac_level = level_for_current();
		end else begin
			case (cmd) inside
				CMD_UP, CMD_DOWN: begin
					if (mode == MODE_CUR) begin
						if (cmd == CMD_UP) begin
							if (cur_step >= CUR_MAX) begin
								cur_step = CUR_MAX;
								ind = IND_LIMIT;
							end else begin
								cur_step++;
								ind = IND_INC;
							end
						end else if (cur_step == 0) begin
							ind = IND_LIMIT;
						end else begin
							cur_step--;
							ind = IND_DEC;
						end
						dac_level = level_for_current();
						save = 1'b1;
					end else if (mode == MODE_FREQ) begin
						if (cmd == CMD_UP) begin
							if (freq_step >= FREQ_MAX) begin
								freq_step = FREQ_MAX;
								ind = IND_LIMIT;
							end else begin
								freq_step++;
								ind = IND_INC;
							end
						end else if (freq_step == 0) begin
							ind = IND_LIMIT;
						end else begin
							freq_step--;
							ind = IND_DEC;
						end
						retime_output();
						save = 1'b1;
					end else begin
						ind = IND_LIMIT;
					end
				end
				CMD_RIGHT: begin
					mode = MODE_FREQ;
					ind = IND_FREQ;
				end
				CMD_LEFT: begin
					mode = MODE_CUR;
					ind = IND_CUR;
				end
				CMD_FRST: begin
					freq_step = '0;
					retime_output();
					ind = IND_RESET;
				end
				CMD_CRST: begin
					cur_step = '0;
					dac_level = level_for_current();
					ind = IND_RESET;
				end
				default: ;
			endcase
		end
		r.dac_level = dac_level;
		r.timer_period = period;
		r.steady_output = steady;
		r.menu_mode = mode;
		r.indication = ind;
		r.save_request = save;
		r.battery_low = low;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t got;
		if (!arst_n) begin
			sense_ohms = SENSE_RST;
			low_mv = LOWBAT_RST;
			mode = MODE_RUN;
			cur_step = CUR_RST;
			freq_step = FREQ_RST;
			supply_mv = '0;
			dac_level = '0;
			period = PERIOD_RST;
			steady = 1'b0;
			low = 1'b0;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = res_t'(m_axis_tdata);
				if (pending_results.size() == 0) begin
					$error("result word %h with nothing expected", m_axis_tdata);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					check_field("dac_level", want.dac_level, got.dac_level);
					check_field("timer_period", want.timer_period, got.timer_period);
					check_field("steady_output", want.steady_output, got.steady_output);
					check_field("menu_mode", want.menu_mode, got.menu_mode);
					check_field("indication", want.indication, got.indication);
					check_field("save_request", want.save_request, got.save_request);
					check_field("battery_low", want.battery_low, got.battery_low);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				apply_word(s_axis_tuser, s_axis_tdata[12:0], s_axis_tdata[20:13], want);
				pending_results.push_back(want);
			end
			if (cfg_we) begin
				if (cfg_index == REG_SENSE)
					sense_ohms = cfg_data;
				else
					low_mv = cfg_data[BATT_W-1:0];
			end
			outstanding <= pending_results.size();
		end
	end

endmodule

FILE: test/remote_setpoint_controller_tb.sv
`timescale 1ns / 1ps
// testbench top for the remote setpoint controller: makes battery and command words,
// register writes and output backpressure, and gives the verdict
// depends on rsc_pkg, remote_setpoint_controller and remote_setpoint_controller_checker

module remote_setpoint_controller_tb;
	import rsc_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_WORDS = 185;
	localparam int DRAIN_CYCLES = 80;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [23:0]        s_axis_tdata = '0;  // battery_mv[12:0], command[20:13], zero pad
	logic               s_axis_tuser = 1'b0;  // kind
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [23:0]        m_axis_tdata;  // dac_level, timer_period, steady_output, menu_mode,
	                                   // indication, save_request, battery_low
	logic               cfg_we = 1'b0;
	logic [0:0]         cfg_index = REG_SENSE;
	logic [SENSE_W-1:0] cfg_data = '0;

	int                 send_idle_pct = 0;
	int                 take_idle_pct = 0;
	int                 holds_asked = 0;
	int                 holds_done = 0;
	int                 hold_left = 0;
	int                 quiet_cycles = 0;
	int                 mismatches;
	int                 outstanding;
	logic [BATT_W-1:0]  threshold_mv = LOWBAT_RST;

	remote_setpoint_controller DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	remote_setpoint_controller_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// result side: random stalls, plus long hold-offs on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else if (holds_done != holds_asked) begin
			holds_done++;
			hold_left = HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= take_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// valid stays high between back-to-back words, dropped only for idle cycles
	task automatic send_word(input logic kind, input logic [BATT_W-1:0] mv,
			input logic [CMD_W-1:0] cb);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {3'b000, cb, mv};
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	task automatic load_settings(input logic [SENSE_W-1:0] ohms, input logic [BATT_W-1:0] low);
		cfg_we <= 1'b1;
		cfg_index <= REG_SENSE;
		cfg_data <= ohms;
		@(posedge clk);
		cfg_index <= REG_LOWBAT;
		cfg_data <= SENSE_W'(low);
		@(posedge clk);
		cfg_we <= 1'b0;
		threshold_mv = low;
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	// mostly menu traffic, some samples (partly around the threshold), some stray bytes
	task automatic send_random_word();
		int pick;
		int mv;
		logic [CMD_W-1:0] cb;
		pick = $urandom_range(99);
		cb = CMD_W'($urandom_range(255));
		mv = $urandom_range(8191);
		if (pick < 25) begin
			case ($urandom_range(9))
				0: mv = 0;
				1: mv = 8191;
				2, 3, 4, 5: begin
					mv = int'(threshold_mv) + int'($urandom_range(400)) - 200;
					if (mv < 0)
						mv = 0;
					if (mv > 8191)
						mv = 8191;
				end
				default: ;
			endcase
			send_word(1'b0, BATT_W'(mv), cb);
		end else begin
			if (pick < 45)
				cb = CMD_UP;
			else if (pick < 65)
				cb = CMD_DOWN;
			else if (pick < 72)
				cb = CMD_RIGHT;
			else if (pick < 79)
				cb = CMD_LEFT;
			else if (pick < 84)
				cb = CMD_FRST;
			else if (pick < 89)
				cb = CMD_CRST;
			send_word(1'b1, BATT_W'(mv), cb);
		end
	endtask

	task automatic run_phase(input logic [SENSE_W-1:0] ohms, input logic [BATT_W-1:0] low,
			input int send_pct, input int take_pct, input bit squeeze);
		load_settings(ohms, low);
		send_idle_pct = send_pct;
		take_idle_pct = take_pct;
		if (squeeze)
			holds_asked++;
		repeat (PHASE_WORDS) send_random_word();
		s_axis_tvalid <= 1'b0;
		wait_drained();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 13;
		take_idle_pct = 84;
		// menu moves before any sample, supply still unknown
		send_word(1'b1, 13'd0, CMD_UP);
		send_word(1'b1, 13'd0, CMD_LEFT);
		send_word(1'b1, 13'd0, CMD_UP);
		send_word(1'b0, 13'd3300, 8'h00);
		send_word(1'b0, 13'd0, 8'h00);
		send_word(1'b1, 13'd0, CMD_DOWN);
		send_word(1'b0, 13'd8191, 8'hff);
		send_word(1'b1, 13'd8191, CMD_LEFT);
		repeat (5) send_word(1'b1, 13'd0, CMD_UP);
		send_word(1'b1, 13'd0, CMD_CRST);
		send_word(1'b1, 13'd0, CMD_DOWN);
		send_word(1'b1, 13'd0, CMD_RIGHT);
		repeat (3) send_word(1'b1, 13'd0, CMD_UP);
		send_word(1'b1, 13'd0, CMD_FRST);
		send_word(1'b1, 13'd0, CMD_DOWN);
		send_word(1'b1, 13'd0, CMD_UP);
		send_word(1'b0, 13'd2499, 8'h00);
		send_word(1'b1, 13'd8191, 8'hff);
		send_word(1'b1, 13'd0, 8'h00);
		send_word(1'b0, 13'd2500, 8'hff);
		s_axis_tvalid <= 1'b0;
		wait_drained();

		run_phase(16'd1, 13'd0, 13, 84, 1'b0);
		run_phase(16'd65535, 13'd8191, 13, 84, 1'b0);
		run_phase(SENSE_W'($urandom_range(3000, 200)), BATT_W'($urandom_range(4000, 2000)),
			84, 13, 1'b0);
		run_phase(16'd1000, 13'd2500, 84, 13, 1'b0);
		run_phase(SENSE_W'($urandom_range(65535, 1)), BATT_W'($urandom_range(8191)), 0, 0, 1'b1);
		run_phase(16'd2200, 13'd3000, 0, 0, 1'b0);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: files.f
src/rsc_pkg.sv
src/rsc_front.sv
src/rsc_div.sv
src/rsc_back.sv
src/remote_setpoint_controller.sv
test/remote_setpoint_controller_checker.sv
test/remote_setpoint_controller_tb.sv
